// File: design/bitmap_block_allocator_core_assert.svh
// Assertion macros for the checker file bba_checker.sv.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define BBA_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/bba_pkg.sv
package bba_pkg;

   localparam int MAX_BLOCKS = 4096;
   localparam int MAX_RUN    = 256;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = MAX_BLOCKS / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int BIT_AW     = $clog2(WORD_BITS);

   localparam logic [1:0] OP_ALLOC_NEXT = 2'd0;
   localparam logic [1:0] OP_ALLOC_AT   = 2'd1;
   localparam logic [1:0] OP_ALLOC_RUN  = 2'd2;
   localparam logic [1:0] OP_FREE       = 2'd3;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOSPACE = 3'd1;
   localparam logic [2:0] ST_INUSE   = 3'd2;
   localparam logic [2:0] ST_RANGE   = 3'd3;
   localparam logic [2:0] ST_FREE    = 3'd4;

   localparam logic CSR_VOLUME = 1'b0;
   localparam logic CSR_GROUP  = 1'b1;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [11:0] block_number;
      logic [8:0]  wanted_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] result_block;
      logic [8:0]  run_length;
      logic [12:0] used_count;
   } rsp_type;

   typedef struct packed {
      logic              found;
      logic [BIT_AW-1:0] free_idx;
      logic [BIT_AW:0]   stop_idx;
   } scan_type;

endpackage

// File: design/bba_ram.sv
module bba_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: design/bba_scan.sv
module bba_scan (
   input  logic [bba_pkg::WORD_BITS-1:0] word_data,
   input  logic [bba_pkg::WORD_AW-1:0]   word_idx,
   input  logic [12:0]                   nb,
   input  logic [11:0]                   start_pt,
   input  logic                          pass,
   input  logic [11:0]                   first,
   input  logic [bba_pkg::BIT_AW-1:0]    pos,
   input  logic [11:0]                   gmask,
   output bba_pkg::scan_type             scan
);
   import bba_pkg::*;

   logic [WORD_BITS-1:0] free_vec;
   logic [WORD_BITS-1:0] stop_vec;
   logic [11:0]          b [WORD_BITS];

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         b[i] = {word_idx, BIT_AW'(i)};
         free_vec[i] = !word_data[i] && ({1'b0, b[i]} < nb)
                       && (pass ? (b[i] < start_pt) : (b[i] >= start_pt));
         stop_vec[i] = (BIT_AW'(i) >= pos)
                       && (word_data[i] || ({1'b0, b[i]} >= nb)
                           || ((b[i] > first) && ((b[i] & gmask) == 12'd0)));
      end
   end

   always_comb begin
      scan.found    = |free_vec;
      scan.free_idx = '0;
      scan.stop_idx = (BIT_AW + 1)'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_vec[i]) begin
            scan.free_idx = BIT_AW'(i);
         end
         if (stop_vec[i]) begin
            scan.stop_idx = (BIT_AW + 1)'(i);
         end
      end
   end
endmodule

// File: design/bitmap_block_allocator_core.sv
// Channel   Handshake           Payload
// request   start / busy        req_data   (opcode, block_number, wanted_length)
// response  rsp_valid strobe    rsp_data   (status, result_block, run_length, used_count)
// config    csr_we              csr_addr, csr_wdata
//
// After reset a clearing pass zeroes all 128 words of the bitmap memory; busy is high.
// Range errors and empty-volume requests are answered from the idle state; single-block requests first read their word.
// Scans read one 32-block memory word per cycle.
// A contiguous run then marks its blocks one memory word at a time, covering at most 9 words.
// Results appear for one cycle and cannot be stalled; busy falls with the result.
module bitmap_block_allocator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bba_pkg::req_type  req_data,
   output logic              rsp_valid,
   output bba_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic              csr_addr,
   input  logic [12:0]       csr_wdata
);
   import bba_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_RUN   = 3'd3;
   localparam logic [2:0] S_BIT   = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [WORD_AW-1:0]   clr_ff, clr_in;
   logic [1:0]           op_ff, op_in;
   logic [11:0]          blk_ff, blk_in;
   logic [8:0]           want_ff, want_in;
   logic [12:0]          nb_ff, nb_in;
   logic [11:0]          start_ff, start_in;
   logic [WORD_AW-1:0]   word_ff, word_in;
   logic                 pass_ff, pass_in;
   logic [11:0]          first_ff, first_in;
   logic [BIT_AW-1:0]    pos_ff, pos_in;
   logic [8:0]           got_ff, got_in;
   logic [12:0]          hint_ff, hint_in;
   logic [12:0]          total_ff, total_in;
   logic [12:0]          vol_ff, vol_in;
   logic [3:0]           gs_ff, gs_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 ram_we, ram_re;
   logic [WORD_AW-1:0]   ram_waddr, ram_raddr;
   logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
   scan_type             scan;

   logic [12:0]          nb_cfg;
   logic [11:0]          start_pt;
   logic [11:0]          gmask;
   logic [12:0]          last_blk;
   logic [BIT_AW:0]      take_lim;
   logic [8:0]           rem;
   logic [BIT_AW:0]      take;
   logic [63:0]          mask64;
   logic [8:0]           got_new;
   logic [12:0]          run_end;
   logic                 cur_bit;

   bba_ram #(.DEPTH(WORD_COUNT), .WIDTH(WORD_BITS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bba_scan u_scan (
      .word_data (ram_rdata),
      .word_idx  (word_ff),
      .nb        (nb_ff),
      .start_pt  (start_ff),
      .pass      (pass_ff),
      .first     (first_ff),
      .pos       (pos_ff),
      .gmask     (gmask),
      .scan      (scan)
   );

   assign nb_cfg   = (vol_ff > 13'(MAX_BLOCKS)) ? 13'(MAX_BLOCKS) : vol_ff;
   assign start_pt = (hint_ff >= nb_cfg) ? 12'd0 : hint_ff[11:0];
   assign gmask    = (gs_ff >= 4'd12) ? 12'hFFF : 12'((13'd1 << gs_ff) - 13'd1);
   assign last_blk = nb_ff - 13'd1;
   assign take_lim = scan.stop_idx - {1'b0, pos_ff};
   assign rem      = want_ff - got_ff;
   assign take     = (rem < {3'd0, take_lim}) ? rem[BIT_AW:0] : take_lim;
   assign mask64   = ((64'd1 << take) - 64'd1) << pos_ff;
   assign got_new  = got_ff + {3'd0, take};
   assign run_end  = {1'b0, first_ff} + {4'd0, got_new};
   assign cur_bit  = ram_rdata[blk_ff[BIT_AW-1:0]];

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      blk_in       = blk_ff;
      want_in      = want_ff;
      nb_in        = nb_ff;
      start_in     = start_ff;
      word_in      = word_ff;
      pass_in      = pass_ff;
      first_in     = first_ff;
      pos_in       = pos_ff;
      got_in       = got_ff;
      hint_in      = hint_ff;
      total_in     = total_ff;
      vol_in       = vol_ff;
      gs_in        = gs_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = word_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = word_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_VOLUME: vol_in = csr_wdata;
            CSR_GROUP:  gs_in  = csr_wdata[3:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + WORD_AW'(1);
            if (clr_ff == WORD_AW'(WORD_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in   = req_data.opcode;
               blk_in  = req_data.block_number;
               want_in = (req_data.wanted_length > 9'(MAX_RUN)) ? 9'(MAX_RUN)
                                                                : req_data.wanted_length;
               nb_in   = nb_cfg;
               case (req_data.opcode)
                  OP_ALLOC_AT, OP_FREE: begin
                     if ({1'b0, req_data.block_number} >= nb_cfg) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{ST_RANGE, req_data.block_number, 9'd0, total_ff};
                     end else begin
                        word_in   = req_data.block_number[11:BIT_AW];
                        ram_re    = 1'b1;
                        ram_raddr = req_data.block_number[11:BIT_AW];
                        state_in  = S_BIT;
                     end
                  end
                  default: begin
                     if (nb_cfg == 13'd0) begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = '{ST_NOSPACE, 12'd0, 9'd0, total_ff};
                     end else begin
                        start_in  = start_pt;
                        pass_in   = 1'b0;
                        word_in   = start_pt[11:BIT_AW];
                        ram_re    = 1'b1;
                        ram_raddr = start_pt[11:BIT_AW];
                        state_in  = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan.found) begin
               first_in = {word_ff, scan.free_idx};
               if (op_ff == OP_ALLOC_NEXT) begin
                  ram_we       = 1'b1;
                  ram_wdata    = ram_rdata | (WORD_BITS'(1) << scan.free_idx);
                  total_in     = total_ff + 13'd1;
                  hint_in      = {1'b0, word_ff, scan.free_idx} + 13'd1;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{ST_OK, {word_ff, scan.free_idx}, 9'd1,
                                   total_ff + 13'd1};
                  state_in     = S_IDLE;
               end else begin
                  pos_in   = scan.free_idx;
                  got_in   = 9'd0;
                  state_in = S_RUN;
               end
            end else if (pass_ff && word_ff == start_ff[11:BIT_AW]) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{ST_NOSPACE, 12'd0, 9'd0, total_ff};
               state_in     = S_IDLE;
            end else begin
               if (!pass_ff && word_ff == last_blk[11:BIT_AW]) begin
                  pass_in = 1'b1;
                  word_in = '0;
               end else begin
                  word_in = word_ff + WORD_AW'(1);
               end
               ram_re    = 1'b1;
               ram_raddr = word_in;
            end
         end
         S_RUN: begin
            ram_we    = (take != '0);
            ram_wdata = ram_rdata | mask64[WORD_BITS-1:0];
            got_in    = got_new;
            if (scan.stop_idx == (BIT_AW + 1)'(WORD_BITS) && got_new < want_ff
                && word_ff != WORD_AW'(WORD_COUNT - 1)) begin
               word_in   = word_ff + WORD_AW'(1);
               pos_in    = '0;
               ram_re    = 1'b1;
               ram_raddr = word_ff + WORD_AW'(1);
            end else begin
               total_in     = total_ff + {4'd0, got_new};
               hint_in      = (run_end >= nb_ff) ? 13'd0 : run_end;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{ST_OK, first_ff, got_new, total_ff + {4'd0, got_new}};
               state_in     = S_IDLE;
            end
         end
         S_BIT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (op_ff == OP_ALLOC_AT) begin
               if (cur_bit) begin
                  rsp_data_in = '{ST_INUSE, blk_ff, 9'd0, total_ff};
               end else begin
                  ram_we      = 1'b1;
                  ram_wdata   = ram_rdata | (WORD_BITS'(1) << blk_ff[BIT_AW-1:0]);
                  total_in    = total_ff + 13'd1;
                  rsp_data_in = '{ST_OK, blk_ff, 9'd1, total_ff + 13'd1};
               end
            end else begin
               if (!cur_bit) begin
                  rsp_data_in = '{ST_FREE, blk_ff, 9'd0, total_ff};
               end else begin
                  ram_we      = 1'b1;
                  ram_wdata   = ram_rdata & ~(WORD_BITS'(1) << blk_ff[BIT_AW-1:0]);
                  total_in    = total_ff - 13'd1;
                  if (hint_ff > {1'b0, blk_ff}) begin
                     hint_in = {1'b0, blk_ff};
                  end
                  rsp_data_in = '{ST_OK, blk_ff, 9'd1, total_ff - 13'd1};
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= '0;
         total_ff     <= '0;
         vol_ff       <= 13'd4096;
         gs_ff        <= 4'd10;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         total_ff     <= total_in;
         vol_ff       <= vol_in;
         gs_ff        <= gs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      blk_ff      <= blk_in;
      want_ff     <= want_in;
      nb_ff       <= nb_in;
      start_ff    <= start_in;
      word_ff     <= word_in;
      pass_ff     <= pass_in;
      first_ff    <= first_in;
      pos_ff      <= pos_in;
      got_ff      <= got_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// File: design/bba_checker.sv
`include "bitmap_block_allocator_core_assert.svh"

module bba_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input bba_pkg::rsp_type rsp_data,
   input logic             rsp_valid
);
   import bba_pkg::*;

   `BBA_ASSERT_CLK(a_accept_progress, clock, reset, start && !busy |=> busy || rsp_valid, "accepted item neither busy nor answered")
   `BBA_ASSERT_CLK(a_result_idle, clock, reset, rsp_valid |-> !busy, "result shown while still busy")
   `BBA_ASSERT_CLK(a_status_code, clock, reset, rsp_valid |-> rsp_data.status <= ST_FREE, "unknown status code")
   `BBA_ASSERT_CLK(a_fail_no_run, clock, reset, rsp_valid && rsp_data.status != ST_OK |-> rsp_data.run_length == 9'd0, "failed request took blocks")
   `BBA_ASSERT_ALWAYS(a_reset_busy, clock, reset |=> busy, "not busy after reset")
endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid)
);

// File: sim/bitmap_block_allocator_core_checker.sv
module bitmap_block_allocator_core_checker
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [12:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic          used_bits [MAX_BLOCKS];
   int unsigned   hint;
   int unsigned   total_used;
   int unsigned   vol_cfg;
   int unsigned   shift_cfg;
   rsp_type       expected_rsps [$];

   function automatic rsp_type allocate(req_type rq);
      rsp_type     r;
      int unsigned nb, first, b, got, want, gmask;
      bit          found;
      nb = (vol_cfg > MAX_BLOCKS) ? MAX_BLOCKS : vol_cfg;
      r = '0;
      r.status = ST_OK;
      found = 0;
      first = 0;
      if ((rq.opcode == OP_ALLOC_NEXT || rq.opcode == OP_ALLOC_RUN) && nb != 0) begin
         b = (hint >= nb) ? 0 : hint;
         for (int i = 0; i < nb && !found; i++) begin
            if (!used_bits[b]) begin
               found = 1;
               first = b;
            end
            b = (b + 1 >= nb) ? 0 : b + 1;
         end
      end
      case (rq.opcode)
         OP_ALLOC_NEXT: begin
            if (found) begin
               used_bits[first] = 1'b1;
               total_used++;
               hint = first + 1;
               r.result_block = 12'(first);
               r.run_length = 9'd1;
            end else begin
               r.status = ST_NOSPACE;
            end
         end
         OP_ALLOC_RUN: begin
            if (found) begin
               gmask = (32'd1 << shift_cfg) - 1;
               want = (rq.wanted_length > MAX_RUN) ? MAX_RUN : rq.wanted_length;
               got = 0;
               while (got < want) begin
                  b = first + got;
                  if (b >= nb || (b > first && (b & gmask) == 0) || used_bits[b]) break;
                  used_bits[b] = 1'b1;
                  got++;
               end
               total_used += got;
               hint = first + got;
               if (hint >= nb) hint = 0;
               r.result_block = 12'(first);
               r.run_length = 9'(got);
            end else begin
               r.status = ST_NOSPACE;
            end
         end
         default: begin
            r.result_block = rq.block_number;
            if (rq.block_number >= nb) begin
               r.status = ST_RANGE;
            end else if (rq.opcode == OP_ALLOC_AT) begin
               if (used_bits[rq.block_number]) begin
                  r.status = ST_INUSE;
               end else begin
                  used_bits[rq.block_number] = 1'b1;
                  total_used++;
                  r.run_length = 9'd1;
               end
            end else if (!used_bits[rq.block_number]) begin
               r.status = ST_FREE;
            end else begin
               used_bits[rq.block_number] = 1'b0;
               total_used--;
               if (hint > rq.block_number) hint = rq.block_number;
               r.run_length = 9'd1;
            end
         end
      endcase
      r.used_count = 13'(total_used);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want_rsp;
      if (reset) begin
         foreach (used_bits[i]) used_bits[i] = 1'b0;
         hint = 0;
         total_used = 0;
         vol_cfg = 4096;
         shift_cfg = 10;
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result %p", rsp_data);
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (rsp_data.status !== want_rsp.status
                   || rsp_data.result_block !== want_rsp.result_block
                   || rsp_data.run_length !== want_rsp.run_length
                   || rsp_data.used_count !== want_rsp.used_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p, got %p", want_rsp, rsp_data);
               end
            end
         end
         if (csr_we) begin
            if (csr_addr == CSR_VOLUME) vol_cfg = csr_wdata;
            else shift_cfg = csr_wdata[3:0];
         end
         if (start && !busy) expected_rsps.push_back(allocate(req_data));
      end
      pending_count = expected_rsps.size();
   end
endmodule

// File: sim/bitmap_block_allocator_core_tb.sv
module bitmap_block_allocator_core_tb;
   import bba_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_VOLUME;
   logic [12:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int unsigned cur_vol;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bitmap_block_allocator_core dut (.*);

   bitmap_block_allocator_core_checker checker_i (.*);

   task automatic send(input logic [1:0] op, input logic [11:0] blk, input logic [8:0] len);
      start <= 1'b1;
      req_data <= '{opcode: op, block_number: blk, wanted_length: len};
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [12:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_VOLUME) cur_vol = value;
   endtask

   task automatic random_item();
      int unsigned sel;
      logic [11:0] blk;
      logic [8:0]  len;
      sel = $urandom_range(0, 99);
      blk = (cur_vol != 0 && $urandom_range(0, 9) != 0)
            ? 12'($urandom_range(0, (cur_vol > 4096 ? 4096 : cur_vol) - 1))
            : 12'($urandom);
      len = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40));
      if (sel < 30) send(OP_ALLOC_NEXT, 12'($urandom), 9'($urandom));
      else if (sel < 50) send(OP_ALLOC_AT, blk, 9'($urandom));
      else if (sel < 70) send(OP_ALLOC_RUN, 12'($urandom), len);
      else send(OP_FREE, blk, 9'($urandom));
   endtask

   initial begin
      int unsigned vols [6];
      int unsigned shifts [6];
      cur_vol = 4096;
      vols = '{4096, 1, 100, 8191, 0, 300};
      shifts = '{10, 0, 3, 15, 12, 4};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (busy) @(posedge clock);

      send(OP_ALLOC_NEXT, 12'd0, 9'd0);
      send(OP_ALLOC_AT, 12'd4095, 9'd0);
      send(OP_ALLOC_AT, 12'd4095, 9'd0);
      send(OP_FREE, 12'd4095, 9'd0);
      send(OP_FREE, 12'd4095, 9'd0);
      send(OP_ALLOC_RUN, 12'd0, 9'd0);
      send(OP_ALLOC_RUN, 12'd0, 9'd511);
      send(OP_ALLOC_RUN, 12'd0, 9'd256);
      send(OP_ALLOC_RUN, 12'd0, 9'd1);
      send(OP_FREE, 12'd0, 9'd0);
      send(OP_ALLOC_NEXT, 12'hfff, 9'h1ff);
      send(OP_ALLOC_AT, 12'd2048, 9'd0);
      send(OP_ALLOC_RUN, 12'd0, 9'd300);
      drain();
      write_reg(CSR_VOLUME, 13'd40);
      write_reg(CSR_GROUP, 13'd3);
      send(OP_ALLOC_AT, 12'd40, 9'd0);
      send(OP_FREE, 12'd4095, 9'd0);
      send(OP_ALLOC_RUN, 12'd0, 9'd20);
      for (int i = 0; i < 8; i++) send(OP_ALLOC_NEXT, 12'd0, 9'd0);
      send(OP_ALLOC_NEXT, 12'd0, 9'd0);

      foreach (vols[p]) begin
         drain();
         write_reg(CSR_VOLUME, 13'(vols[p]));
         write_reg(CSR_GROUP, 13'(shifts[p]));
         for (int n = 0; n < 90;) begin
            int unsigned burst;
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
               random_item();
               n++;
            end
            if ($urandom_range(0, 2) != 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end
         end
      end
      drain();
      if (fail_count == 0) $display("bitmap_block_allocator_core_tb: PASS");
      else $display("bitmap_block_allocator_core_tb: FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("bitmap_block_allocator_core_tb: FAIL");
      $finish;
   end
endmodule
